// ===== sv/indexed_record_list_store_macros.svh =====
// Assertion helpers for the record list store
`ifndef INDEXED_RECORD_LIST_STORE_MACROS_SVH
`define INDEXED_RECORD_LIST_STORE_MACROS_SVH

// same-cycle implication
`define IRLS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IRLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/irls_pkg.sv =====
package irls_pkg;

  localparam int MAX_RECORDS = 256;
  localparam int ADDR_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  position;
    logic [31:0] rec_time;
    logic [31:0] rec_lat_bits;
    logic [31:0] rec_lon_bits;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] out_time;
    logic [31:0] out_lat_bits;
    logic [31:0] out_lon_bits;
    logic [8:0]  count_now;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DEL_CHK,
    ST_DEL_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic cap;
    logic rd_pos;
    logic rd_next;
    logic wr_app;
    logic wr_shift;
    logic idx_load;
    logic idx_inc;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic pend_set;
    logic pend_ok;
    logic pend_rd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic             append_ok;
    logic             index_ok;
    logic             del_more;
    logic [CNT_W-1:0] count;
  } dp_stat_t;

endpackage

// ===== sv/irls_dp.sv =====
module irls_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  irls_pkg::in_item_t   in_data,
  input  irls_pkg::ctrl_cmd_t  cc,
  output irls_pkg::dp_stat_t   st,
  output irls_pkg::out_item_t  out_data
);

  irls_pkg::in_item_t              item;
  logic [irls_pkg::CNT_W-1:0]      count;
  logic [irls_pkg::ADDR_W-1:0]     idx;
  logic [95:0]                     rdata;
  logic                            pend_ok;
  logic                            pend_rd;
  irls_pkg::out_item_t             res;
  logic [95:0]                     mem [irls_pkg::MAX_RECORDS];

  logic                            wr_en;
  logic [irls_pkg::ADDR_W-1:0]     wr_addr;
  logic [95:0]                     wr_data;
  logic                            rd_en;
  logic [irls_pkg::ADDR_W-1:0]     rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cc.cnt_clr) begin
      count <= '0;
    end else if (cc.cnt_inc) begin
      count <= count + irls_pkg::CNT_W'(1);
    end else if (cc.cnt_dec) begin
      count <= count - irls_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cc.cap) begin
      item <= in_data;
    end
    if (cc.idx_load) begin
      idx <= irls_pkg::ADDR_W'(item.position);
    end else if (cc.idx_inc) begin
      idx <= idx + irls_pkg::ADDR_W'(1);
    end
    if (cc.pend_set) begin
      pend_ok <= cc.pend_ok;
      pend_rd <= cc.pend_rd;
    end
  end

  always_comb begin
    wr_en   = cc.wr_app | cc.wr_shift;
    wr_addr = cc.wr_app ? irls_pkg::ADDR_W'(count) : idx;
    wr_data = cc.wr_app ? {item.rec_time, item.rec_lat_bits, item.rec_lon_bits} : rdata;
    rd_en   = cc.rd_pos | cc.rd_next;
    rd_addr = cc.rd_pos ? irls_pkg::ADDR_W'(item.position) : (idx + irls_pkg::ADDR_W'(1));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cc.out_load) begin
      res.ok        <= pend_ok;
      res.out_time     <= pend_rd ? rdata[95:64] : 32'd0;
      res.out_lat_bits <= pend_rd ? rdata[63:32] : 32'd0;
      res.out_lon_bits <= pend_rd ? rdata[31:0]  : 32'd0;
      res.count_now    <= 9'(count);
    end
  end

  always_comb begin
    st.cmd       = item.cmd;
    st.append_ok = count < irls_pkg::CNT_W'(irls_pkg::MAX_RECORDS);
    st.index_ok  = irls_pkg::CMP_W'(item.position) < irls_pkg::CMP_W'(count);
    st.del_more  = (irls_pkg::CNT_W'(idx) + irls_pkg::CNT_W'(1)) < count;
    st.count     = count;
  end

  assign out_data = res;

endmodule

// ===== sv/irls_ctrl.sv =====
module irls_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  irls_pkg::dp_stat_t   st,
  output irls_pkg::ctrl_cmd_t  cc
);

  irls_pkg::state_t state;
  irls_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= irls_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cc.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cc         = '0;
    state_next = state;
    in_ready   = (state == irls_pkg::ST_IDLE);
    unique case (state)
      irls_pkg::ST_IDLE: begin
        if (in_valid) begin
          cc.cap     = 1'b1;
          state_next = irls_pkg::ST_EXEC;
        end
      end
      irls_pkg::ST_EXEC: begin
        cc.pend_set = 1'b1;
        state_next  = irls_pkg::ST_RESP;
        unique case (st.cmd)
          irls_pkg::CMD_APPEND: begin
            if (st.append_ok) begin
              cc.wr_app  = 1'b1;
              cc.cnt_inc = 1'b1;
              cc.pend_ok = 1'b1;
            end
          end
          irls_pkg::CMD_READ: begin
            if (st.index_ok) begin
              cc.rd_pos  = 1'b1;
              cc.pend_ok = 1'b1;
              cc.pend_rd = 1'b1;
            end
          end
          irls_pkg::CMD_DELETE: begin
            if (st.index_ok) begin
              cc.idx_load = 1'b1;
              cc.pend_ok  = 1'b1;
              state_next  = irls_pkg::ST_DEL_CHK;
            end
          end
          irls_pkg::CMD_CLEAR: begin
            cc.cnt_clr = 1'b1;
            cc.pend_ok = 1'b1;
          end
          default: begin
          end
        endcase
      end
      irls_pkg::ST_DEL_CHK: begin
        if (st.del_more) begin
          cc.rd_next = 1'b1;
          state_next = irls_pkg::ST_DEL_WR;
        end else begin
          cc.cnt_dec = 1'b1;
          state_next = irls_pkg::ST_RESP;
        end
      end
      irls_pkg::ST_DEL_WR: begin
        cc.wr_shift = 1'b1;
        cc.idx_inc  = 1'b1;
        state_next  = irls_pkg::ST_DEL_CHK;
      end
      irls_pkg::ST_RESP: begin
        if (!out_valid || out_ready) begin
          cc.out_load = 1'b1;
          state_next  = irls_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = irls_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/indexed_record_list_store.sv =====
// Ordered list of 96-bit records in a single-port-write, single-port-read RAM.
// Input channel in_valid/in_ready/in_data carries one command per transaction:
// append, read, delete or clear. Output channel out_valid/out_ready/out_data
// returns exactly one result per command: ok, the record for a good read
// (zero otherwise) and the record count after the command.
// One command is in work at a time; in_ready is high only when the
// sequencer is idle. Append, read, clear and refused commands pass from
// EXEC to RESP; in_ready returns with out_valid, so a new command is taken
// only once the last result is loaded. A delete at position p with count n
// moves n-1-p records through the RAM, with one read and one write per record
// in the states DEL_CHK and DEL_WR, then lowers the count and goes to RESP.
// The RAM's single read port and registered read data split each record move.
// The result sits in an output register: if the receiver stalls, the next
// command is still accepted and worked on, and only its final result load
// waits until the register is free.
// Synchronous reset clears the count and the handshake state; record RAM
// contents are not cleared and no clearing pass is needed.
`include "indexed_record_list_store_macros.svh"

module indexed_record_list_store (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  irls_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output irls_pkg::out_item_t  out_data
);

  irls_pkg::ctrl_cmd_t cc;
  irls_pkg::dp_stat_t  st;

  irls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cc        (cc)
  );

  irls_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cc       (cc),
    .st       (st),
    .out_data (out_data)
  );

  `IRLS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready,
    "accepted while busy")
  `IRLS_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1,
    st.count <= irls_pkg::CNT_W'(irls_pkg::MAX_RECORDS), "count over capacity")
  `IRLS_ASSERT_IMPL(a_load_free, clk, rst, cc.out_load, !out_valid || out_ready,
    "result overwritten")

endmodule
